@@ rtl/hec_pkg.sv @@
// ----------------------------------------------------------------------------
// hec_pkg
// shared types and constants of the hessian extrema classifier
// ----------------------------------------------------------------------------
package hec_pkg;

    // geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // field widths
    localparam int HESS_BITS  = 16;
    localparam int PROD_BITS  = 2 * HESS_BITS;
    localparam int DET_BITS   = PROD_BITS + 1;
    localparam int TRACE_BITS = HESS_BITS + 1;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int KIND_W     = 2;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = HGT_W;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(1024);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(1024);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    typedef logic signed [DET_BITS-1:0]   t_det;
    typedef logic signed [TRACE_BITS-1:0] t_trace;

    typedef enum logic [KIND_W-1:0] {
        KIND_MAX    = 2'd0,
        KIND_MIN    = 2'd1,
        KIND_SADDLE = 2'd2
    } t_point_kind;

    // one line memory entry per column
    typedef struct packed {
        t_det   det_mid;
        t_det   det_up;
        t_trace tr_mid;
    } t_line_entry;

    // one reported hit
    typedef struct packed {
        t_det             det;
        t_point_kind      kind;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_hit;

endpackage

@@ rtl/hessian_extrema_classifier_top.sv @@
// ----------------------------------------------------------------------------
// hessian_extrema_classifier_top
// determinant-of-hessian 3x3 non-maximum suppression with eigenvalue classing
// ----------------------------------------------------------------------------
// Takes one pixel of hessian terms (fxx, fxy, fyy, signed Q8.8) per request in
// raster order and reports every interior pixel whose determinant is not below
// any of its eight neighbors, classed as maximum, minimum or saddle; a zero
// determinant, or a positive one with zero trace, is dropped. Rate is one
// pixel per clock unless held off: the line store is a single 1024-entry
// memory holding, per column, the middle-row det, the upper-row det and the
// middle-row trace, read and written once per pixel, and that memory port sets
// the rate. A hit for pixel (r-1,c-1) comes out with the pixel (r,c) that
// completes its window, after stage 2. Input ready drops only when the
// four-entry result queue could not take the results still in flight. The
// line memory is not cleared after reset: the first two rows of a frame never
// report, so stale entries are never used. frame_width and frame_height are
// clamped to 3..1024 and 3..4096 and take effect at once; the raster counters
// are not cleared by a write, so write them between frames.
// ----------------------------------------------------------------------------
module hessian_extrema_classifier_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [hec_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [hec_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // pixel requests
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // hess_xx [15:0], hess_xy [31:16], hess_yy [47:32]
    input  logic [hec_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // hit requests
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // pixel_row [11:0], pixel_col [21:12], det_value [54:22], zero [55]
    output logic [hec_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // point_kind [1:0]
    output logic [hec_pkg::KIND_W-1:0]           o_m_axis_tuser
);

    localparam int HB = hec_pkg::HESS_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [hec_pkg::WID_W-1:0] r_frame_width;
    logic [hec_pkg::HGT_W-1:0] r_frame_height;
    logic [hec_pkg::WID_W-1:0] w_width;
    logic [hec_pkg::HGT_W-1:0] w_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= hec_pkg::WIDTH_RESET;
            r_frame_height <= hec_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hec_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[hec_pkg::WID_W-1:0];
                hec_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp to the supported frame size
    always_comb begin
        if (r_frame_width < hec_pkg::WID_W'(3))
            w_width = hec_pkg::WID_W'(3);
        else if (r_frame_width > hec_pkg::WID_W'(hec_pkg::MAX_WIDTH))
            w_width = hec_pkg::WID_W'(hec_pkg::MAX_WIDTH);
        else
            w_width = r_frame_width;

        if (r_frame_height < hec_pkg::HGT_W'(3))
            w_height = hec_pkg::HGT_W'(3);
        else if (r_frame_height > hec_pkg::HGT_W'(hec_pkg::MAX_HEIGHT))
            w_height = hec_pkg::HGT_W'(hec_pkg::MAX_HEIGHT);
        else
            w_height = r_frame_height;
    end

    // ------------------------------------------------------------------
    // input request and raster counters
    // ------------------------------------------------------------------
    logic                          w_accept;
    logic signed [HB-1:0]          w_fxx, w_fxy, w_fyy;
    logic [hec_pkg::COL_W-1:0]     r_col, n_col;
    logic [hec_pkg::ROW_W-1:0]     r_row, n_row;
    logic [hec_pkg::WID_W-1:0]     w_col_inc;
    logic [hec_pkg::HGT_W-1:0]     w_row_inc;
    logic                          w_report;

    assign w_fxx    = i_s_axis_tdata[HB-1:0];
    assign w_fxy    = i_s_axis_tdata[2*HB-1:HB];
    assign w_fyy    = i_s_axis_tdata[3*HB-1:2*HB];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign w_col_inc = {1'b0, r_col} + hec_pkg::WID_W'(1);
    assign w_row_inc = {1'b0, r_row} + hec_pkg::HGT_W'(1);

    // window center is one row and one column behind; borders never report
    assign w_report = (r_row >= hec_pkg::ROW_W'(2)) && (r_col >= hec_pkg::COL_W'(2))
                   && ({1'b0, r_col} < w_width) && ({1'b0, r_row} < w_height);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_col_inc >= w_width) begin
                n_col = '0;
                n_row = (w_row_inc >= w_height) ? '0 : w_row_inc[hec_pkg::ROW_W-1:0];
            end else begin
                n_col = w_col_inc[hec_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: products, trace, line memory read
    // ------------------------------------------------------------------
    hec_pkg::t_line_entry                r_line_mem [hec_pkg::MAX_WIDTH];
    hec_pkg::t_line_entry                r_rd;
    logic                                r_v1;
    logic signed [hec_pkg::PROD_BITS-1:0] r_prod_xxyy, r_prod_xyxy;
    hec_pkg::t_trace                     r_tr1;
    logic [hec_pkg::ADDR_W-1:0]          r_a1;
    logic                                r_rpt1;
    logic [hec_pkg::ROW_W-1:0]           r_row1;
    logic [hec_pkg::COL_W-1:0]           r_col1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else
            r_v1 <= w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod_xxyy <= w_fxx * w_fyy;
            r_prod_xyxy <= w_fxy * w_fxy;
            r_tr1       <= hec_pkg::t_trace'(w_fxx) + hec_pkg::t_trace'(w_fyy);
            r_a1        <= r_col[hec_pkg::ADDR_W-1:0];
            r_rpt1      <= w_report;
            r_row1      <= r_row - hec_pkg::ROW_W'(1);
            r_col1      <= r_col - hec_pkg::COL_W'(1);
            r_rd        <= r_line_mem[r_col[hec_pkg::ADDR_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: determinant, line write-back, window shift
    // consecutive pixels always hit different columns, so the write here
    // never meets a read of the same entry
    // ------------------------------------------------------------------
    hec_pkg::t_det             w_det1;
    hec_pkg::t_det             r_win [3][3];   // [upper, middle, new][oldest..newest]
    hec_pkg::t_trace           r_tr_pair [2];  // [0] newest column, [1] window center
    logic                      r_v2;
    logic                      r_rpt2;
    logic [hec_pkg::ROW_W-1:0] r_row2;
    logic [hec_pkg::COL_W-1:0] r_col2;

    assign w_det1 = hec_pkg::t_det'(r_prod_xxyy) - hec_pkg::t_det'(r_prod_xyxy);

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_line_mem[r_a1] <= '{det_mid: w_det1, det_up: r_rd.det_mid, tr_mid: r_tr1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2]  <= r_rd.det_up;
            r_win[1][2]  <= r_rd.det_mid;
            r_win[2][2]  <= w_det1;
            r_tr_pair[1] <= r_tr_pair[0];
            r_tr_pair[0] <= r_rd.tr_mid;
            r_rpt2       <= r_rpt1;
            r_row2       <= r_row1;
            r_col2       <= r_col1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v2 <= 1'b0;
        else
            r_v2 <= r_v1;
    end

    // ------------------------------------------------------------------
    // stage 3: suppression and classing
    // ------------------------------------------------------------------
    hec_pkg::t_det       w_cd;
    hec_pkg::t_trace     w_ct;
    logic                w_cand;
    logic                w_kind_ok;
    hec_pkg::t_point_kind w_kind;
    logic                w_push;
    hec_pkg::t_hit       w_hit;

    assign w_cd = r_win[1][1];
    assign w_ct = r_tr_pair[1];

    always_comb begin
        w_cand = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (w_cd < r_win[i][j])
                    w_cand = 1'b0;
            end
        end
    end

    always_comb begin
        w_kind_ok = 1'b1;
        w_kind    = hec_pkg::KIND_SADDLE;
        if (w_cd == '0) begin
            w_kind_ok = 1'b0;
        end else if (w_cd < 0) begin
            w_kind = hec_pkg::KIND_SADDLE;
        end else if (w_ct < 0) begin
            w_kind = hec_pkg::KIND_MAX;
        end else if (w_ct > 0) begin
            w_kind = hec_pkg::KIND_MIN;
        end else begin
            w_kind_ok = 1'b0;
        end
    end

    assign w_push = r_v2 && r_rpt2 && w_cand && w_kind_ok;
    assign w_hit  = '{det: w_cd, kind: w_kind, col: r_col2, row: r_row2};

    // ------------------------------------------------------------------
    // result queue; input is held off while the queue could overflow
    // with the pixels still in the pipeline
    // ------------------------------------------------------------------
    hec_pkg::t_hit                  r_fifo [hec_pkg::FIFO_DEPTH];
    logic [hec_pkg::FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [hec_pkg::FIFO_CNT_W-1:0] r_count, n_count;
    logic [hec_pkg::FIFO_CNT_W:0]   w_committed;
    logic                           w_pop;
    hec_pkg::t_hit                  w_head;

    assign w_pop   = o_m_axis_tvalid && i_m_axis_tready;
    assign w_head  = r_fifo[r_rd_ptr];
    assign n_count = r_count + hec_pkg::FIFO_CNT_W'(w_push) - hec_pkg::FIFO_CNT_W'(w_pop);

    assign w_committed = {1'b0, r_count} + (hec_pkg::FIFO_CNT_W+1)'(r_v1)
                       + (hec_pkg::FIFO_CNT_W+1)'(r_v2);
    assign o_s_axis_tready = w_committed < (hec_pkg::FIFO_CNT_W+1)'(hec_pkg::FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push)
                r_wr_ptr <= r_wr_ptr + hec_pkg::FIFO_PTR_W'(1);
            if (w_pop)
                r_rd_ptr <= r_rd_ptr + hec_pkg::FIFO_PTR_W'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push)
            r_fifo[r_wr_ptr] <= w_hit;
    end

    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {1'b0, w_head.det, w_head.col, w_head.row};
    assign o_m_axis_tuser  = w_head.kind;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // credit scheme keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && !w_pop && r_count == hec_pkg::FIFO_CNT_W'(hec_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    // queued plus in-flight results never exceed the queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_committed <= (hec_pkg::FIFO_CNT_W+1)'(hec_pkg::FIFO_DEPTH))
        else $error("credit count exceeds queue depth");

    // a line write never lands on the column read in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_accept) |-> (r_a1 != r_col[hec_pkg::ADDR_W-1:0]))
        else $error("line memory read and write on the same column");

    // a reported hit never carries a zero determinant or an unused kind
    a_hit_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_head.det != '0 && o_m_axis_tuser != 2'd3))
        else $error("malformed hit in result queue");

    // a hit is only queued for a pixel request that has passed stage 1 and stage 2
    a_push_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> $past(w_accept, 2))
        else $error("hit queued without a matching pixel");

endmodule

@@ tb/hessian_extrema_classifier_top_test.sv @@
// ----------------------------------------------------------------------------
// hessian_extrema_classifier_top_test
// self-checking bench for the determinant-of-hessian extrema classifier
// ----------------------------------------------------------------------------
// Streams raster frames of hessian terms into the block and keeps a cycle-free
// copy of its line stores, 3x3 det window and raster counters to predict every
// hit. Each accepted hit is matched field by field against the oldest
// prediction. Frames start with hand-built cases (tied max/min, saddle, a zero
// determinant), then a register write in the middle of a frame, a long output
// stall on a frame mostly of ties, short runs at the clamped widest and tallest
// geometry, and finally random frames, mostly small, with mixed content.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hessian_extrema_classifier_top_test;

    localparam int SETTLE_CYCLES = 16;    // pipeline drain before a register write
    localparam int TAIL_CYCLES   = 32;    // quiet time after the last hit
    localparam int LONG_HOLD     = 400;   // long receiver stall, in cycles
    localparam int STALL_LIMIT   = 5000;  // watchdog: cycles without any handshake
    localparam int RANDOM_PIXELS = 1100;
    localparam int WIDE_PIXELS   = 200;   // part of a row at the widest geometry
    localparam int TALL_PIXELS   = 61;    // first rows at the tallest geometry

    // pixel content of a frame
    typedef enum int {
        PIX_TIE_PAIR,
        PIX_SADDLE_ZERO,
        PIX_WIDE,
        PIX_SMALL,
        PIX_EXTREME,
        PIX_SADDLE,
        PIX_PLATEAU
    } t_pix_mode;

    // ------------------------------------------------------------------------
    // predicted hits and the state that produces them
    // ------------------------------------------------------------------------
    class t_hit_ledger;
        hec_pkg::t_det   det_up_line  [hec_pkg::MAX_WIDTH] = '{default: '0};
        hec_pkg::t_det   det_mid_line [hec_pkg::MAX_WIDTH] = '{default: '0};
        hec_pkg::t_trace tr_mid_line  [hec_pkg::MAX_WIDTH] = '{default: '0};
        hec_pkg::t_det   det_win [3][3] = '{default: '0};  // [upper,middle,new][old..new]
        hec_pkg::t_trace tr_pair [2]    = '{default: '0};  // [0] newest, [1] centre
        int unsigned     col_cnt = 0;
        int unsigned     row_cnt = 0;
        logic [hec_pkg::WID_W-1:0] width_reg  = hec_pkg::WIDTH_RESET;
        logic [hec_pkg::HGT_W-1:0] height_reg = hec_pkg::HEIGHT_RESET;
        hec_pkg::t_hit   awaited_hits [$];
        int              mismatches  = 0;
        int              pixels_seen = 0;
        int              hits_seen   = 0;
        int              kind_seen [3] = '{default: 0};

        function void set_reg(logic [hec_pkg::CFG_ADDR_W-1:0] idx,
                              logic [hec_pkg::CFG_DATA_W-1:0] val);
            if (idx == hec_pkg::REG_FRAME_WIDTH)
                width_reg = val[hec_pkg::WID_W-1:0];
            else
                height_reg = val[hec_pkg::HGT_W-1:0];
        endfunction

        // one accepted pixel: shift the window, update the lines, maybe predict a hit
        function void log_pixel(logic [hec_pkg::IN_DATA_W-1:0] px);
            logic signed [hec_pkg::HESS_BITS-1:0] xx, xy, yy;
            longint               prod;
            hec_pkg::t_det        det_now;
            hec_pkg::t_trace      tr_now;
            int unsigned          w, h, c, r, a;
            hec_pkg::t_det        centre;
            hec_pkg::t_trace      centre_tr;
            bit                   peak;
            bit                   classed;
            hec_pkg::t_point_kind kind;
            hec_pkg::t_hit        e;
            xx = px[15:0];
            xy = px[31:16];
            yy = px[47:32];
            prod = longint'(xx) * longint'(yy) - longint'(xy) * longint'(xy);
            det_now = hec_pkg::t_det'(prod);
            tr_now = hec_pkg::t_trace'(longint'(xx) + longint'(yy));
            w = width_reg;
            if (w < 3) w = 3;
            if (w > hec_pkg::MAX_WIDTH) w = hec_pkg::MAX_WIDTH;
            h = height_reg;
            if (h < 3) h = 3;
            if (h > hec_pkg::MAX_HEIGHT) h = hec_pkg::MAX_HEIGHT;
            c = col_cnt;
            r = row_cnt;
            a = c % hec_pkg::MAX_WIDTH;
            pixels_seen++;

            for (int i = 0; i < 3; i++) begin
                det_win[i][0] = det_win[i][1];
                det_win[i][1] = det_win[i][2];
            end
            det_win[0][2] = det_up_line[a];
            det_win[1][2] = det_mid_line[a];
            det_win[2][2] = det_now;
            tr_pair[1] = tr_pair[0];
            tr_pair[0] = tr_mid_line[a];
            det_up_line[a]  = det_mid_line[a];
            det_mid_line[a] = det_now;
            tr_mid_line[a]  = tr_now;

            if (r >= 2 && c >= 2 && c < w && r < h) begin
                centre = det_win[1][1];
                centre_tr = tr_pair[1];
                peak = 1'b1;
                foreach (det_win[i, j])
                    if (centre < det_win[i][j]) peak = 1'b0;
                if (peak && centre != 0) begin
                    classed = 1'b1;
                    kind = hec_pkg::KIND_MAX;
                    if (centre < 0)
                        kind = hec_pkg::KIND_SADDLE;
                    else if (centre_tr < 0)
                        kind = hec_pkg::KIND_MAX;
                    else if (centre_tr > 0)
                        kind = hec_pkg::KIND_MIN;
                    else
                        classed = 1'b0;
                    if (classed) begin
                        e.row  = hec_pkg::ROW_W'(r - 1);
                        e.col  = hec_pkg::COL_W'(c - 1);
                        e.kind = kind;
                        e.det  = centre;
                        awaited_hits.insert(awaited_hits.size(), e);
                    end
                end
            end

            if (c + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (r + 1 >= h) ? 0 : ((r + 1) & 32'hFFF);
            end else begin
                col_cnt = (c + 1) & 32'h3FF;
            end
        endfunction

        function void flag(string what, longint exp_v, longint act_v);
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, what, exp_v, act_v);
        endfunction

        // one accepted hit against the oldest prediction
        function void match_hit(logic [hec_pkg::OUT_DATA_W-1:0] data,
                                logic [hec_pkg::KIND_W-1:0] user);
            hec_pkg::t_hit e;
            if (awaited_hits.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected hit, expected none, got row %0d col %0d",
                         $time, data[11:0], data[21:12]);
                return;
            end
            e = awaited_hits.pop_front();
            hits_seen++;
            kind_seen[int'(e.kind)]++;
            if (data[11:0] != e.row)   flag("pixel_row", e.row, data[11:0]);
            if (data[21:12] != e.col)  flag("pixel_col", e.col, data[21:12]);
            if (user != e.kind)        flag("point_kind", e.kind, user);
            if (data[54:22] != e.det)
                flag("det_value", longint'(e.det), longint'($signed(data[54:22])));
            if (data[55] != 1'b0)      flag("tdata pad bit", 0, data[55]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block and its stimulus signals
    // ------------------------------------------------------------------------
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [hec_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [hec_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // hess_xx [15:0], hess_xy [31:16], hess_yy [47:32]
    logic [hec_pkg::IN_DATA_W-1:0]   i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // pixel_row [11:0], pixel_col [21:12], det_value [54:22], zero [55]
    logic [hec_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;
    // point_kind [1:0]
    logic [hec_pkg::KIND_W-1:0]      o_m_axis_tuser;

    hessian_extrema_classifier_top dut (.*);

    t_hit_ledger ledger = new;
    int          send_calm = 0;      // remaining gap-free pixel requests
    int          sink_calm = 0;      // remaining stall-free hit requests
    bit          rush = 1'b0;        // sender offers back to back
    bit          hold_request = 1'b0;
    int          long_holds = 0;
    int          reg_writes = 0;
    int          frames_done = 0;
    int          quiet_cycles = 0;
    int unsigned cur_w = 0;
    int unsigned cur_h = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog: nothing moving for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[hessian_extrema_classifier_top] ERROR");
            $finish;
        end
    end

    // gap before the next request: usually a random one, with stretches of none
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // hessian terms for the pixel at (r, c) of the current frame
    function automatic logic [hec_pkg::IN_DATA_W-1:0] make_pixel(
            t_pix_mode mode, logic [hec_pkg::IN_DATA_W-1:0] base,
            int unsigned r, int unsigned c);
        logic [15:0] xx, xy, yy;
        logic [15:0] picks [8];
        picks = '{16'h8000, 16'h8001, 16'hFF00, 16'hFFFF,
                  16'h0000, 16'h0001, 16'h0100, 16'h7FFF};
        xx = $urandom();
        xy = $urandom();
        yy = $urandom();
        case (mode)
            PIX_TIE_PAIR: begin
                // equal dets side by side: one maximum, one minimum
                if (r == 1 && c == 1)
                    {yy, xy, xx} = {16'hFF00, 16'h0000, 16'hFF00};
                else if (r == 1 && c == 2)
                    {yy, xy, xx} = {16'h0100, 16'h0000, 16'h0100};
                else
                    {yy, xy, xx} = {16'h8000, 16'h7FFF, 16'h7FFF};
            end
            PIX_SADDLE_ZERO: begin
                // saddle at column 1, zero determinant peak at column 3
                if (r == 1 && c == 1)
                    {yy, xy, xx} = {16'hFFFF, 16'hFFFF, 16'h0001};
                else if (r == 1 && c == 3)
                    {yy, xy, xx} = '0;
                else
                    {yy, xy, xx} = {16'h7FFF, 16'h8000, 16'h8000};
            end
            PIX_SMALL: begin
                xx = 16'($urandom_range(0, 8)) - 16'd4;
                xy = 16'($urandom_range(0, 8)) - 16'd4;
                yy = 16'($urandom_range(0, 8)) - 16'd4;
            end
            PIX_EXTREME: begin
                xx = picks[$urandom_range(0, 7)];
                xy = picks[$urandom_range(0, 7)];
                yy = picks[$urandom_range(0, 7)];
            end
            PIX_SADDLE: begin
                // opposite-sign diagonal keeps every det negative
                xx = 16'($urandom_range(1, 32767));
                yy = 16'd0 - 16'($urandom_range(1, 32768));
            end
            PIX_PLATEAU: begin
                if ($urandom_range(0, 15) == 0) begin
                    xx = 16'($urandom_range(0, 8)) - 16'd4;
                    xy = 16'($urandom_range(0, 8)) - 16'd4;
                    yy = 16'($urandom_range(0, 8)) - 16'd4;
                end else begin
                    {yy, xy, xx} = base;
                end
            end
            default: ;
        endcase
        return {yy, xy, xx};
    endfunction

    // one pixel request, held until the block takes it
    task automatic send_pixel(input logic [hec_pkg::IN_DATA_W-1:0] px);
        int gap;
        gap = rush ? 0 : draw_gap(send_calm);
        @(negedge i_clk);
        repeat (gap) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
        ledger.log_pixel(px);
    endtask

    // stop offering, let every predicted hit arrive, then let the pipe settle
    task automatic drain(input int extra);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (ledger.awaited_hits.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [hec_pkg::CFG_ADDR_W-1:0] idx,
                             input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= hec_pkg::CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.set_reg(idx, hec_pkg::CFG_DATA_W'(val));
        reg_writes++;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        drain(SETTLE_CYCLES);
        write_reg(hec_pkg::REG_FRAME_WIDTH, w);
        write_reg(hec_pkg::REG_FRAME_HEIGHT, h);
        cur_w = w;
        cur_h = h;
    endtask

    // pixels until the raster counters come back to the frame start
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input t_pix_mode mode,
                             input logic [hec_pkg::IN_DATA_W-1:0] base);
        if (w != cur_w || h != cur_h)
            set_geometry(w, h);
        do begin
            send_pixel(make_pixel(mode, base, ledger.row_cnt, ledger.col_cnt));
        end while (ledger.col_cnt != 0 || ledger.row_cnt != 0);
        frames_done++;
    endtask

    // hit receiver: random stalls, one long stall on request
    initial begin : hit_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap(sink_calm);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
                long_holds++;
            end
            @(negedge i_clk);
            repeat (gap) begin
                i_m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            ledger.match_hit(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    initial begin : stimulus
        int unsigned w, h, start, left;
        t_pix_mode   mode;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hand-built frames: tied max/min pair, then saddle beside a zero det
        run_frame(4, 3, PIX_TIE_PAIR, '0);
        run_frame(5, 3, PIX_SADDLE_ZERO, '0);

        // width shrinks in the middle of a frame; upper data bits are masked off
        set_geometry(10, 6);
        repeat (35) send_pixel(make_pixel(PIX_WIDE, '0, 0, 0));
        drain(SETTLE_CYCLES);
        write_reg(hec_pkg::REG_FRAME_WIDTH, 13'h1804);
        cur_w = 4;
        run_frame(4, 6, PIX_WIDE, '0);

        // frame mostly of ties; every tied interior pixel reports while the receiver stalls
        set_geometry(12, 10);
        hold_request = 1'b1;
        rush = 1'b1;
        run_frame(12, 10, PIX_PLATEAU, {16'h0100, 16'h0000, 16'h0100});
        rush = 1'b0;

        // geometry limits, written out of range: part of a widest row, then the
        // first rows of a tallest frame, then a short frame ends the tall one
        set_geometry(1025, 0);
        repeat (WIDE_PIXELS) send_pixel(make_pixel(PIX_WIDE, '0, 0, 0));
        set_geometry(2, 8191);
        repeat (TALL_PIXELS) send_pixel(make_pixel(PIX_EXTREME, '0, 0, 0));
        run_frame(3, 3, PIX_SMALL, '0);

        // random frames, mostly small
        start = ledger.pixels_seen;
        while (ledger.pixels_seen - start < RANDOM_PIXELS) begin
            left = RANDOM_PIXELS - (ledger.pixels_seen - start);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
            if (w * h > left)
                h = (left / w < 3) ? 3 : left / w;
            mode = t_pix_mode'($urandom_range(PIX_WIDE, PIX_PLATEAU));
            run_frame(w, h, mode, make_pixel(PIX_EXTREME, '0, 0, 0));
        end

        drain(TAIL_CYCLES);
        $display("run: %0d pixels in %0d frames, %0d register writes, %0d long stalls",
                 ledger.pixels_seen, frames_done, reg_writes, long_holds);
        $display("run: %0d hits checked (%0d max, %0d min, %0d saddle)", ledger.hits_seen,
                 ledger.kind_seen[hec_pkg::KIND_MAX], ledger.kind_seen[hec_pkg::KIND_MIN],
                 ledger.kind_seen[hec_pkg::KIND_SADDLE]);
        if (ledger.mismatches == 0 && ledger.awaited_hits.size() == 0)
            $display("[hessian_extrema_classifier_top] OK");
        else
            $display("[hessian_extrema_classifier_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hec_pkg.sv
rtl/hessian_extrema_classifier_top.sv
tb/hessian_extrema_classifier_top_test.sv
